### hw/rtl/gvi_pkg.sv
package gvi_pkg;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_SIZE_X    = 3'd0;
   localparam logic [2:0] CSR_SIZE_Y    = 3'd1;
   localparam logic [2:0] CSR_SIZE_Z    = 3'd2;
   localparam logic [2:0] CSR_USE_SCALE = 3'd3;
   localparam logic [2:0] CSR_SCALE_X   = 3'd4;
   localparam logic [2:0] CSR_SCALE_Y   = 3'd5;
   localparam logic [2:0] CSR_SCALE_Z   = 3'd6;

   localparam int POS_BITS   = 15;
   localparam int INDEX_BITS = 15;
   localparam int VALUE_BITS = 16;
   localparam int SIZE_BITS  = 6;
   localparam int SCALE_BITS = 12;
   localparam int COUNT_BITS = 5;
   localparam int WEIGHT_BITS = 17;
   localparam int CSR_DATA_BITS = 12;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture query and compute center
      logic first;     // neighbor counter and accumulator reset
      logic visit;     // issue one neighbor read
      logic accum;     // accumulate neighbor in flight; unused, accumulation follows the visit pipeline
      logic div_start; // start the divider
   } gvi_cmd_type;

   typedef struct packed {
      logic last_visit; // final neighbor issued
      logic div_done;
   } gvi_status_type;

   // weight entry k, about 65536*exp(-16k/depth), exact integer recipe
   function automatic logic [WEIGHT_BITS-1:0] weight_entry(input int k, input int depth);
      logic [63:0] a, s, term;
      a = (64'(k) << 26) / 64'(depth);
      s = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * a) >> 30) / 64'(n);
         if (n % 2 == 1) s = s - term;
         else s = s + term;
      end
      for (int j = 0; j < 8; j++) s = (s * s + (64'd1 << 29)) >> 30;
      return WEIGHT_BITS'((s + 64'd8192) >> 14);
   endfunction

endpackage

### hw/rtl/gvi_if.sv
interface gvi_req_if;
   import gvi_pkg::*;
   logic valid;
   logic ready;
   logic req_type;
   logic [INDEX_BITS-1:0] voxel_index;
   logic signed [VALUE_BITS-1:0] voxel_value;
   logic signed [POS_BITS-1:0] pos_x;
   logic signed [POS_BITS-1:0] pos_y;
   logic signed [POS_BITS-1:0] pos_z;
   modport source (output valid, req_type, voxel_index, voxel_value, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, req_type, voxel_index, voxel_value, pos_x, pos_y, pos_z,
                 output ready);
endinterface

interface gvi_rsp_if;
   import gvi_pkg::*;
   logic valid;
   logic ready;
   logic signed [VALUE_BITS-1:0] interp_value;
   logic [COUNT_BITS-1:0] neighbours_used;
   modport source (output valid, interp_value, neighbours_used, input ready);
   modport sink (input valid, interp_value, neighbours_used, output ready);
endinterface

interface gvi_csr_if;
   import gvi_pkg::*;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/gvi_divider.sv
// Restoring divider, one quotient bit per cycle: q = num / (2*den)
module gvi_divider #(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS:0]   den_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS+1:0] trial;

   // one shift and subtract step
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[NUM_BITS-1]};
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = (DEN_BITS+1)'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = (DEN_BITS+1)'(trial);
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) den_ff <= {den, 1'b0};
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

### hw/rtl/gvi_datapath.sv
// Neighbor walk, weight lookup, accumulation and final mean
module gvi_datapath #(
   parameter int MAX_X = 32,
   parameter int MAX_Y = 32,
   parameter int MAX_Z = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int WEIGHT_TABLE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gvi_pkg::gvi_cmd_type              cmd,
   output gvi_pkg::gvi_status_type           status,
   input  logic                              wr_en,
   input  logic [gvi_pkg::INDEX_BITS-1:0]    wr_index,
   input  logic [gvi_pkg::VALUE_BITS-1:0]    wr_value,
   input  logic signed [gvi_pkg::POS_BITS-1:0] pos_x,
   input  logic signed [gvi_pkg::POS_BITS-1:0] pos_y,
   input  logic signed [gvi_pkg::POS_BITS-1:0] pos_z,
   input  logic [gvi_pkg::SIZE_BITS-1:0]     size_x,
   input  logic [gvi_pkg::SIZE_BITS-1:0]     size_y,
   input  logic [gvi_pkg::SIZE_BITS-1:0]     size_z,
   input  logic                              use_scale,
   input  logic [gvi_pkg::SCALE_BITS-1:0]    scale_x,
   input  logic [gvi_pkg::SCALE_BITS-1:0]    scale_y,
   input  logic [gvi_pkg::SCALE_BITS-1:0]    scale_z,
   output logic signed [gvi_pkg::VALUE_BITS-1:0] interp_value,
   output logic [gvi_pkg::COUNT_BITS-1:0]    neighbours_used
);
   import gvi_pkg::*;

   localparam int XB = $clog2(MAX_X);
   localparam int YB = $clog2(MAX_Y);
   localparam int ZB = $clog2(MAX_Z);
   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AB = XB + YB + ZB;
   localparam int TB = $clog2(WEIGHT_TABLE_DEPTH);
   localparam int CB = 9;              // center coordinate, signed
   localparam int DB = 18;             // offset in Q8, signed
   localparam int MB = 29;             // |offset| * scale
   localparam int SQB = 58;
   localparam int R2B = 60;
   localparam int ACCB = SAMPLE_BITS + WEIGHT_BITS + 5 + 1;
   localparam int WSB = WEIGHT_BITS + 5;
   localparam int NUMB = ACCB;

   // sample memory
   logic [SAMPLE_BITS-1:0] mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [AB-1:0]          rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_index) < DEPTH)) mem[AB'(wr_index)] <= SAMPLE_BITS'(wr_value);
      rd_data_ff <= mem[rd_addr];
   end

   // query capture: relative position and rounded center
   logic signed [DB-1:0] qx_ff, qy_ff, qz_ff;
   logic signed [CB-1:0] cx_ff, cy_ff, cz_ff;
   logic [SCALE_BITS-1:0] sx_ff, sy_ff, sz_ff;
   logic [SIZE_BITS:0] nx_ff, ny_ff, nz_ff;

   function automatic logic signed [CB-1:0] round_center(input logic signed [DB-1:0] q);
      logic [DB-1:0] m;
      m = q[DB-1] ? DB'(-q) : DB'(q);
      m = (m + DB'(128)) >> 8;
      return q[DB-1] ? -CB'(m) : CB'(m);
   endfunction

   function automatic logic [SIZE_BITS:0] clamp(input logic [SIZE_BITS-1:0] s, input int mx);
      return (32'(s) > mx) ? (SIZE_BITS+1)'(mx) : {1'b0, s};
   endfunction

   logic signed [DB-1:0] qx_w, qy_w, qz_w;
   assign qx_w = DB'(pos_x) - DB'(256);
   assign qy_w = DB'(pos_y) - DB'(256);
   assign qz_w = DB'(pos_z) - DB'(256);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         qx_ff <= qx_w;
         qy_ff <= qy_w;
         qz_ff <= qz_w;
         cx_ff <= round_center(qx_w);
         cy_ff <= round_center(qy_w);
         cz_ff <= round_center(qz_w);
         sx_ff <= use_scale ? scale_x : SCALE_BITS'(256);
         sy_ff <= use_scale ? scale_y : SCALE_BITS'(256);
         sz_ff <= use_scale ? scale_z : SCALE_BITS'(256);
         nx_ff <= clamp(size_x, MAX_X);
         ny_ff <= clamp(size_y, MAX_Y);
         nz_ff <= clamp(size_z, MAX_Z);
      end
   end

   // neighbor counter: offsets -1..1 on each axis, x fastest
   logic [1:0] ox_ff, oy_ff, oz_ff;
   logic signed [CB:0] x_w, y_w, z_w;
   logic inside_w;
   logic last_visit_w;
   logic div_done_w;
   assign x_w = (CB+1)'(cx_ff) + (CB+1)'($signed({1'b0, ox_ff})) - (CB+1)'(1);
   assign y_w = (CB+1)'(cy_ff) + (CB+1)'($signed({1'b0, oy_ff})) - (CB+1)'(1);
   assign z_w = (CB+1)'(cz_ff) + (CB+1)'($signed({1'b0, oz_ff})) - (CB+1)'(1);
   assign inside_w = !x_w[CB] && !y_w[CB] && !z_w[CB]
                     && (x_w < $signed({3'b000, nx_ff}))
                     && (y_w < $signed({3'b000, ny_ff}))
                     && (z_w < $signed({3'b000, nz_ff}));
   // linear address x + MAX_X*(y + MAX_Y*z)
   assign rd_addr = AB'(32'(x_w[XB-1:0])
                        + MAX_X * (32'(y_w[YB-1:0]) + MAX_Y * 32'(z_w[ZB-1:0])));
   assign last_visit_w = (ox_ff == 2'd2) && (oy_ff == 2'd2) && (oz_ff == 2'd2);
   assign status = '{last_visit: last_visit_w, div_done: div_done_w};

   always_ff @(posedge clock) begin
      if (cmd.first) begin
         ox_ff <= '0;
         oy_ff <= '0;
         oz_ff <= '0;
      end else if (cmd.visit) begin
         if (ox_ff == 2'd2) begin
            ox_ff <= '0;
            if (oy_ff == 2'd2) begin
               oy_ff <= '0;
               oz_ff <= oz_ff + 2'd1;
            end else oy_ff <= oy_ff + 2'd1;
         end else ox_ff <= ox_ff + 2'd1;
      end
   end

   // stage 1: offsets magnitudes
   logic [DB-1:0] dx_w, dy_w, dz_w;
   function automatic logic [DB-1:0] absdiff(input logic signed [CB:0] n,
                                             input logic signed [DB-1:0] q);
      logic signed [DB-1:0] d;
      d = (DB'(n) <<< 8) - q;
      return d[DB-1] ? DB'(-d) : DB'(d);
   endfunction
   assign dx_w = absdiff(x_w, qx_ff);
   assign dy_w = absdiff(y_w, qy_ff);
   assign dz_w = absdiff(z_w, qz_ff);

   logic [DB-1:0] dx1_ff, dy1_ff, dz1_ff;
   logic          v1_ff, in1_ff;
   logic [MB-1:0] mx2_ff, my2_ff, mz2_ff;
   logic          v2_ff, in2_ff;
   logic [SQB-1:0] qx3_ff, qy3_ff, qz3_ff;
   logic          v3_ff, in3_ff;
   logic [TB:0]   k4_ff;
   logic          v4_ff, in4_ff, far4_ff;
   logic [R2B-1:0] r2_w;
   logic [R2B+TB:0] kx_w;

   assign r2_w = R2B'(qx3_ff) + R2B'(qy3_ff) + R2B'(qz3_ff);
   assign kx_w = ((R2B+TB+1)'(r2_w) << TB) + ((R2B+TB+1)'(1) << 34);

   // table lookup: ROM built at elaboration
   logic [WEIGHT_BITS-1:0] wtab [WEIGHT_TABLE_DEPTH];
   for (genvar g = 0; g < WEIGHT_TABLE_DEPTH; g++) begin : g_tab
      assign wtab[g] = weight_entry(g, WEIGHT_TABLE_DEPTH);
   end

   logic [WEIGHT_BITS-1:0] w5_ff;
   logic v5_ff;
   logic signed [ACCB-1:0] acc_ff;
   logic [WSB-1:0] wsum_ff;
   logic [COUNT_BITS-1:0] used_ff;

   // weight pipeline: read, multiply, square, sum and index, table, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.visit;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff && in4_ff && !far4_ff;
      end
      in1_ff <= inside_w;
      dx1_ff <= dx_w; dy1_ff <= dy_w; dz1_ff <= dz_w;
      in2_ff <= in1_ff;
      mx2_ff <= MB'(dx1_ff) * MB'(sx_ff);
      my2_ff <= MB'(dy1_ff) * MB'(sy_ff);
      mz2_ff <= MB'(dz1_ff) * MB'(sz_ff);
      in3_ff <= in2_ff;
      qx3_ff <= SQB'(mx2_ff) * SQB'(mx2_ff);
      qy3_ff <= SQB'(my2_ff) * SQB'(my2_ff);
      qz3_ff <= SQB'(mz2_ff) * SQB'(mz2_ff);
      in4_ff <= in3_ff;
      far4_ff <= (kx_w >> 35) >= (R2B+TB+1)'(WEIGHT_TABLE_DEPTH);
      k4_ff <= (TB+1)'(kx_w >> 35);
      w5_ff <= wtab[k4_ff[TB-1:0]];
   end

   // accumulators; sample read lags the visit, aligned with stage 1 and delayed to stage 5
   logic [SAMPLE_BITS-1:0] d2_ff, d3_ff, d4_ff, d5_ff;
   always_ff @(posedge clock) begin
      d2_ff <= rd_data_ff;
      d3_ff <= d2_ff;
      d4_ff <= d3_ff;
      d5_ff <= d4_ff;
      if (cmd.first) begin
         acc_ff <= '0;
         wsum_ff <= '0;
         used_ff <= '0;
      end else begin
         if (v5_ff) begin
            acc_ff <= acc_ff + ACCB'($signed({1'b0, w5_ff}) * $signed(d5_ff));
            wsum_ff <= wsum_ff + WSB'(w5_ff);
         end
         if (v4_ff && in4_ff) used_ff <= used_ff + 1'b1;
      end
   end

   // mean by division, sign restored afterwards
   logic [NUMB-1:0] mag_w, quot;
   logic signed [ACCB-1:0] res_w;
   assign mag_w = acc_ff[ACCB-1] ? NUMB'(-acc_ff) : NUMB'(acc_ff);

   logic [NUMB-1:0] num_w;
   assign num_w = NUMB'((mag_w << 1) + NUMB'(wsum_ff));

   gvi_divider #(.NUM_BITS(NUMB), .DEN_BITS(WSB)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_w),
      .den   (wsum_ff),
      .done  (div_done_w),
      .quot  (quot)
   );

   assign res_w = acc_ff[ACCB-1] ? -ACCB'(quot) : ACCB'(quot);
   assign interp_value = (wsum_ff == '0) ? '0 : VALUE_BITS'(res_w);
   assign neighbours_used = used_ff;
endmodule

### hw/rtl/gvi_ctrl.sv
// Sequencer: accept, 27 visits, pipeline drain, divide, present result
module gvi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_is_query,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gvi_pkg::gvi_cmd_type    cmd,
   input  gvi_pkg::gvi_status_type status
);
   import gvi_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_VISIT, S_DRAIN, S_DIV, S_WAIT, S_OUT
   } state_type;

   localparam int DRAIN = 7;

   state_type state_ff, state_in;
   logic [2:0] drain_ff, drain_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      drain_in = drain_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_is_query) begin
               cmd.load = 1'b1;
               cmd.first = 1'b1;
               state_in = S_VISIT;
            end
         end
         S_VISIT: begin
            cmd.visit = 1'b1;
            if (status.last_visit) begin
               drain_in = 3'(DRAIN);
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff - 3'd1;
            if (drain_ff == 3'd1) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (status.div_done) begin
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         drain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

### hw/rtl/gaussian_volume_interpolator.sv
// A write is done when accepted; with no query in progress a transaction is taken every cycle.
// A query holds the input until its result is taken: 27 neighbor reads on the
// single read port, a pipeline drain, a divider start state and the divider run
// come before the result is put out. The result register holds until taken;
// the next transaction can be taken in the cycle after.
// Synchronous active high reset restores the register defaults; sample memory
// is not cleared and reads of unwritten entries return undefined data.
module gaussian_volume_interpolator #(
   parameter int MAX_X = 32,
   parameter int MAX_Y = 32,
   parameter int MAX_Z = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int WEIGHT_TABLE_DEPTH = 256
) (
   input logic clock,
   input logic reset,
   gvi_req_if.sink   req,
   gvi_rsp_if.source rsp,
   gvi_csr_if.sink   csr
);
   import gvi_pkg::*;

   logic [SIZE_BITS-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic use_scale_ff;
   logic [SCALE_BITS-1:0] scale_x_ff, scale_y_ff, scale_z_ff;
   gvi_cmd_type cmd;
   gvi_status_type status;
   logic ctrl_ready;

   // configuration registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_BITS'(32);
         size_y_ff <= SIZE_BITS'(32);
         size_z_ff <= SIZE_BITS'(32);
         use_scale_ff <= 1'b0;
         scale_x_ff <= SCALE_BITS'(256);
         scale_y_ff <= SCALE_BITS'(256);
         scale_z_ff <= SCALE_BITS'(256);
      end else if (csr.valid) begin
         case (csr.index)
            CSR_SIZE_X:    size_x_ff <= csr.data[SIZE_BITS-1:0];
            CSR_SIZE_Y:    size_y_ff <= csr.data[SIZE_BITS-1:0];
            CSR_SIZE_Z:    size_z_ff <= csr.data[SIZE_BITS-1:0];
            CSR_USE_SCALE: use_scale_ff <= csr.data[0];
            CSR_SCALE_X:   scale_x_ff <= csr.data;
            CSR_SCALE_Y:   scale_y_ff <= csr.data;
            CSR_SCALE_Z:   scale_z_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign req.ready = ctrl_ready;

   gvi_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_is_query (req.req_type == REQ_QUERY),
      .req_ready    (ctrl_ready),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .cmd          (cmd),
      .status       (status)
   );

   gvi_datapath #(
      .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z),
      .SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_TABLE_DEPTH(WEIGHT_TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .wr_en           (req.valid && ctrl_ready && (req.req_type == REQ_WRITE)),
      .wr_index        (req.voxel_index),
      .wr_value        (req.voxel_value),
      .pos_x           (req.pos_x),
      .pos_y           (req.pos_y),
      .pos_z           (req.pos_z),
      .size_x          (size_x_ff),
      .size_y          (size_y_ff),
      .size_z          (size_z_ff),
      .use_scale       (use_scale_ff),
      .scale_x         (scale_x_ff),
      .scale_y         (scale_y_ff),
      .scale_z         (scale_z_ff),
      .interp_value    (rsp.interp_value),
      .neighbours_used (rsp.neighbours_used)
   );
endmodule

### hw/rtl/gvi_checker.sv
module gvi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_type,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [4:0] neighbours_used
);
   import gvi_pkg::*;

   // a result waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no new transaction while a result is pending
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken with result pending");

   // a write never causes a result next cycle
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("result after write");

   // count is bounded by the neighborhood
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> neighbours_used <= 5'd27)
      else $error("neighbor count out of range");
endmodule

bind gaussian_volume_interpolator gvi_checker u_chk (
   .clock (clock),
   .reset (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_type (req.req_type),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .neighbours_used (rsp.neighbours_used)
);

### bench/tb_gaussian_volume_interpolator.sv
`timescale 1ns / 1ps

module tb_gaussian_volume_interpolator;
   import gvi_pkg::*;

   typedef struct packed {
      logic                  req_type;
      logic [INDEX_BITS-1:0] voxel_index;
      logic signed [VALUE_BITS-1:0] voxel_value;
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic signed [POS_BITS-1:0] pos_z;
   } voxel_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] interp_value;
      logic [COUNT_BITS-1:0]        neighbours_used;
   } mean_type;

   localparam int DIM = 32;
   localparam int VOXELS = DIM * DIM * DIM;
   localparam int DEPTH = 256;
   localparam int FILL = 8;

   logic clock;
   logic reset;

   gvi_req_if req_ch ();
   gvi_rsp_if rsp_ch ();
   gvi_csr_if csr_ch ();

   gaussian_volume_interpolator dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   // shadow of the block state
   logic signed [VALUE_BITS-1:0] shadow_volume [VOXELS];
   longint gauss_lut [DEPTH];
   int size_x_m, size_y_m, size_z_m;
   bit scale_on_m;
   int scale_x_m, scale_y_m, scale_z_m;

   voxel_req_type pending_reqs[$];
   mean_type      pending_means[$];
   voxel_req_type cur_req;
   int  errors;
   int  send_gap;
   int  recv_stall;
   int  hold_cnt;
   bit  hold_go;
   bit  quiet;

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Gaussian weight table, Q16, exp(-16k/DEPTH) by series and squaring
   task automatic fill_gauss_lut();
      longint unsigned a, s, term;
      for (int k = 0; k < DEPTH; k++) begin
         a = (longint'(k) << 26) / DEPTH;
         s = 64'd1 << 30;
         term = 64'd1 << 30;
         for (int n = 1; n <= 6; n++) begin
            term = ((term * a) >> 30) / n;
            if (n % 2 == 1) s = s - term;
            else s = s + term;
         end
         for (int j = 0; j < 8; j++) s = (s * s + (64'd1 << 29)) >> 30;
         gauss_lut[k] = longint'((s + 64'd8192) >> 14);
      end
   endtask

   function automatic longint round_q8(input longint q);
      if (q >= 0) return (q + 128) >>> 8;
      return -((-q + 128) >>> 8);
   endfunction

   function automatic mean_type predict_mean(input voxel_req_type it);
      longint qx, qy, qz, cx, cy, cz, x, y, z, r2, k, d, acc, wsum, mag, quo, res;
      int nx, ny, nz, sx, sy, sz, used;
      mean_type m;
      qx = longint'(it.pos_x) - 256;
      qy = longint'(it.pos_y) - 256;
      qz = longint'(it.pos_z) - 256;
      cx = round_q8(qx);
      cy = round_q8(qy);
      cz = round_q8(qz);
      nx = size_x_m > DIM ? DIM : size_x_m;
      ny = size_y_m > DIM ? DIM : size_y_m;
      nz = size_z_m > DIM ? DIM : size_z_m;
      sx = scale_on_m ? scale_x_m : 256;
      sy = scale_on_m ? scale_y_m : 256;
      sz = scale_on_m ? scale_z_m : 256;
      acc = 0;
      wsum = 0;
      used = 0;
      for (int dz = -1; dz <= 1; dz++)
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
               x = cx + dx;
               y = cy + dy;
               z = cz + dz;
               if (x < 0 || x >= nx || y < 0 || y >= ny || z < 0 || z >= nz) continue;
               used++;
               d = x * 256 - qx;
               d = (d < 0 ? -d : d) * sx;
               r2 = d * d;
               d = y * 256 - qy;
               d = (d < 0 ? -d : d) * sy;
               r2 += d * d;
               d = z * 256 - qz;
               d = (d < 0 ? -d : d) * sz;
               r2 += d * d;
               k = (r2 * DEPTH + (64'd1 << 34)) >>> 35;
               if (k >= DEPTH) continue;
               acc += gauss_lut[k] * longint'(shadow_volume[x + DIM * (y + DIM * z)]);
               wsum += gauss_lut[k];
            end
      res = 0;
      if (wsum != 0) begin
         mag = acc < 0 ? -acc : acc;
         quo = (2 * mag + wsum) / (2 * wsum);
         res = acc < 0 ? -quo : quo;
      end
      m.interp_value = res[VALUE_BITS-1:0];
      m.neighbours_used = used[COUNT_BITS-1:0];
      return m;
   endfunction

   // request driver: accept at posedge, present next at negedge
   bit req_fired;
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_fired = 1'b1;
         if (cur_req.req_type == REQ_WRITE) shadow_volume[cur_req.voxel_index] = cur_req.voxel_value;
         else pending_means.push_back(predict_mean(cur_req));
      end
   end

   always @(negedge clock) begin
      if (!reset && !(req_ch.valid && !req_fired)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.req_type    <= cur_req.req_type;
            req_ch.voxel_index <= cur_req.voxel_index;
            req_ch.voxel_value <= cur_req.voxel_value;
            req_ch.pos_x       <= cur_req.pos_x;
            req_ch.pos_y       <= cur_req.pos_y;
            req_ch.pos_z       <= cur_req.pos_z;
            if (!quiet && $urandom_range(0, 19) == 0) send_gap = $urandom_range(1, 10);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      mean_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_means.size() == 0) begin
            report_mismatch("unexpected result, value", rsp_ch.interp_value, 0);
         end else begin
            want = pending_means.pop_front();
            if (rsp_ch.interp_value !== want.interp_value)
               report_mismatch("interp_value", rsp_ch.interp_value, want.interp_value);
            if (rsp_ch.neighbours_used !== want.neighbours_used)
               report_mismatch("neighbours_used", rsp_ch.neighbours_used, want.neighbours_used);
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_go && hold_cnt == 0) begin
         hold_cnt = 600;
         hold_go = 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
      end
   end

   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 10);
      end
   end

   task automatic write_csr(input logic [2:0] idx, input int val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val[CSR_DATA_BITS-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_SIZE_X:    size_x_m = val & 63;
         CSR_SIZE_Y:    size_y_m = val & 63;
         CSR_SIZE_Z:    size_z_m = val & 63;
         CSR_USE_SCALE: scale_on_m = val[0];
         CSR_SCALE_X:   scale_x_m = val & 4095;
         CSR_SCALE_Y:   scale_y_m = val & 4095;
         CSR_SCALE_Z:   scale_z_m = val & 4095;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_config(input int sx, input int sy, input int sz, input int on,
                             input int kx, input int ky, input int kz);
      write_csr(CSR_SIZE_X, sx);
      write_csr(CSR_SIZE_Y, sy);
      write_csr(CSR_SIZE_Z, sz);
      write_csr(CSR_USE_SCALE, on);
      write_csr(CSR_SCALE_X, kx);
      write_csr(CSR_SCALE_Y, ky);
      write_csr(CSR_SCALE_Z, kz);
   endtask

   task automatic push_write(input int addr, input int val);
      voxel_req_type it;
      it = '0;
      it.req_type = REQ_WRITE;
      it.voxel_index = addr[INDEX_BITS-1:0];
      it.voxel_value = val[VALUE_BITS-1:0];
      it.pos_x = POS_BITS'($urandom);
      it.pos_y = POS_BITS'($urandom);
      it.pos_z = POS_BITS'($urandom);
      pending_reqs.push_back(it);
   endtask

   task automatic push_query(input int px, input int py, input int pz);
      voxel_req_type it;
      it.req_type = REQ_QUERY;
      it.voxel_index = INDEX_BITS'($urandom);
      it.voxel_value = VALUE_BITS'($urandom);
      it.pos_x = px[POS_BITS-1:0];
      it.pos_y = py[POS_BITS-1:0];
      it.pos_z = pz[POS_BITS-1:0];
      pending_reqs.push_back(it);
   endtask

   // position near the filled corner: voxel -2..9, random fraction; sometimes anywhere
   function automatic int rand_pos();
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 24575)) - 8192;
      return 256 * (int'($urandom_range(0, 11)) - 1) + int'($urandom_range(0, 255)) - 128;
   endfunction

   task automatic drain_all();
      wait (pending_reqs.size() == 0 && !req_ch.valid && pending_means.size() == 0);
      // a trailing write may still be in flight
      repeat (120) @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 3)
            push_write($urandom_range(0, VOXELS - 1), $urandom);
         else
            push_query(rand_pos(), rand_pos(), rand_pos());
      end
   endtask

   // sequencer
   initial begin
      errors = 0;
      send_gap = 0;
      recv_stall = 0;
      hold_cnt = 0;
      hold_go = 1'b0;
      quiet = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_WRITE;
      req_ch.voxel_index = '0;
      req_ch.voxel_value = '0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_SIZE_X;
      csr_ch.data = '0;
      size_x_m = 32;
      size_y_m = 32;
      size_z_m = 32;
      scale_on_m = 1'b0;
      scale_x_m = 256;
      scale_y_m = 256;
      scale_z_m = 256;
      fill_gauss_lut();
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the low 8x8x8 corner; queries only ever reach inside neighbors there
      for (int z = 0; z < FILL; z++)
         for (int y = 0; y < FILL; y++)
            for (int x = 0; x < FILL; x++) push_write(x + DIM * (y + DIM * z), $urandom);
      // extreme samples around one spot
      push_write(5 + 32 * 5 + 1024 * 5, 32767);
      push_write(6 + 32 * 5 + 1024 * 5, -32768);
      push_write(5 + 32 * 6 + 1024 * 5, 32767);
      // corners, half-voxel rounding both ways, far outside, field extremes
      push_query(256, 256, 256);
      push_query(256 * 34, 256 * 34, 256 * 34);
      push_query(384, 384, 384);
      push_query(128, 128, 128);
      push_query(256 * 6 + 128, 256 * 6, 256 * 6);
      push_query(-8192, -8192, -8192);
      push_query(16383, 16383, 16383);
      push_query(-8192, 16383, 256);
      push_query(256 * 6, 256 * 6 + 77, 256 * 6 - 77);
      push_query(0, 256 * 16, 256 * 40);
      drain_all();

      // all scales at max: weights vanish beside the centre
      set_config(32, 32, 32, 1, 4095, 4095, 4095);
      push_query(256 * 6 + 100, 256 * 6, 256 * 6);
      push_query(256 * 4 + 128, 256 * 4 + 128, 256 * 4 + 128);
      // size zero and scale zero
      drain_all();
      set_config(0, 32, 32, 1, 0, 1, 256);
      push_query(256, 256, 256);
      drain_all();
      // sizes above the maximum clamp to it
      set_config(63, 63, 63, 1, 0, 0, 0);
      push_query(256 * 34, 256 * 2, 256 * 2);
      push_query(256 * 3 + 50, 256 * 4, 256 * 5);
      push_query(256 * 7, 256 * 7, 256 * 7);
      drain_all();

      // random phases over several settings
      set_config(1, 1, 1, 0, 256, 256, 256);
      random_phase(150);
      drain_all();
      set_config(7, 5, 8, 1, 1, 4095, 128);
      random_phase(150);
      // receiver holds off while requests keep coming
      hold_go = 1'b1;
      drain_all();
      for (int p = 0; p < 6; p++) begin
         set_config($urandom_range(1, FILL), $urandom_range(1, FILL), $urandom_range(1, FILL),
                    $urandom_range(0, 1), $urandom_range(1, 4095), $urandom_range(1, 600),
                    $urandom_range(64, 512));
         random_phase(150);
         drain_all();
      end
      set_config(FILL, FILL, FILL, 0, 256, 256, 256);
      quiet = 1'b1;
      random_phase(100);
      drain_all();

      if (errors == 0) begin
         $display("[gaussian_volume_interpolator] OK");
      end else begin
         $display("[gaussian_volume_interpolator] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("[gaussian_volume_interpolator] ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/gvi_pkg.sv
hw/rtl/gvi_if.sv
hw/rtl/gvi_divider.sv
hw/rtl/gvi_datapath.sv
hw/rtl/gvi_ctrl.sv
hw/rtl/gaussian_volume_interpolator.sv
hw/rtl/gvi_checker.sv
bench/tb_gaussian_volume_interpolator.sv
